@@ sv/pes_pkg.sv @@
// shared types and constants for the execute stage
package pes_pkg;

	localparam int PredEntries = 256;
	localparam int PredIdxW = $clog2(PredEntries);
	localparam int QueueDepth = 2;
	localparam int QueueIdxW = $clog2(QueueDepth);

	typedef enum logic [4:0] {
		OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3,
		OP_EQ = 5'd4, OP_NEQ = 5'd5, OP_LT = 5'd6, OP_GT = 5'd7,
		OP_LE = 5'd8, OP_GE = 5'd9, OP_AND = 5'd10, OP_OR = 5'd11,
		OP_XOR = 5'd12, OP_SHL = 5'd13, OP_SHR = 5'd14, OP_LOAD = 5'd15,
		OP_STORE = 5'd16, OP_SYSCALL = 5'd17, OP_JUMPCOND = 5'd18, OP_MOV = 5'd19
	} opcode_t;

	localparam logic [1:0] MEM_NONE = 2'd0;
	localparam logic [1:0] MEM_READ = 2'd1;
	localparam logic [1:0] MEM_WRITE = 2'd2;

	typedef enum logic [2:0] {
		CLS_NOP, CLS_ALU, CLS_DIV, CLS_LOAD, CLS_STORE, CLS_SYS, CLS_JUMP, CLS_MOV
	} cls_t;

	// classified instruction passed from front to back
	typedef struct packed {
		logic        live;
		cls_t        cls;
		logic [4:0]  opcode;
		logic [15:0] value_a;
		logic [15:0] value_b;
		logic [3:0]  dest_reg;
		logic [15:0] immediate;
		logic [7:0]  pc;
		logic [15:0] predicted_target;
	} instr_t;

	typedef struct packed {
		logic              out_valid;
		logic              write_reg;
		logic [3:0]        target_reg;
		logic [15:0]       alu_result;
		logic [1:0]        mem_access;
		logic [15:0]       mem_address;
		logic [15:0]       mem_write_data;
		logic              halt;
		logic              redirect;
		logic [15:0]       redirect_pc;
		logic signed [2:0] history_counter;
	} result_t;

endpackage

@@ sv/pes_front.sv @@
// front end: accepts beats, classifies them and fills the instruction queue
module pes_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [82:0]     in_data,
	output logic            q_valid,
	input  logic            q_ready,
	output pes_pkg::instr_t q_data
);
	pes_pkg::instr_t                 cls_instr;
	pes_pkg::instr_t                 mem_q [pes_pkg::QueueDepth];
	logic [pes_pkg::QueueIdxW-1:0]   wr_q;
	logic [pes_pkg::QueueIdxW-1:0]   rd_q;
	logic [pes_pkg::QueueIdxW:0]     cnt_q;
	logic                            push;
	logic                            pop;

	always_comb begin
		cls_instr.live = ~in_data[0] & in_data[1];
		cls_instr.opcode = in_data[6:2];
		cls_instr.value_a = in_data[22:7];
		cls_instr.value_b = in_data[38:23];
		cls_instr.dest_reg = in_data[42:39];
		cls_instr.immediate = in_data[58:43];
		cls_instr.pc = in_data[66:59];
		cls_instr.predicted_target = in_data[82:67];
		if (cls_instr.opcode inside {[pes_pkg::OP_ADD:pes_pkg::OP_MUL],
				[pes_pkg::OP_EQ:pes_pkg::OP_SHR]})
			cls_instr.cls = pes_pkg::CLS_ALU;
		else begin
			case (cls_instr.opcode)
				pes_pkg::OP_DIV:      cls_instr.cls = pes_pkg::CLS_DIV;
				pes_pkg::OP_LOAD:     cls_instr.cls = pes_pkg::CLS_LOAD;
				pes_pkg::OP_STORE:    cls_instr.cls = pes_pkg::CLS_STORE;
				pes_pkg::OP_SYSCALL:  cls_instr.cls = pes_pkg::CLS_SYS;
				pes_pkg::OP_JUMPCOND: cls_instr.cls = pes_pkg::CLS_JUMP;
				pes_pkg::OP_MOV:      cls_instr.cls = pes_pkg::CLS_MOV;
				default:              cls_instr.cls = pes_pkg::CLS_NOP;
			endcase
		end
	end

	assign in_ready = cnt_q != (pes_pkg::QueueIdxW+1)'(pes_pkg::QueueDepth);
	assign q_valid = cnt_q != '0;
	assign q_data = mem_q[rd_q];
	assign push = in_valid & in_ready;
	assign pop = q_valid & q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (pes_pkg::QueueIdxW+1)'(push) - (pes_pkg::QueueIdxW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= cls_instr;
	end
endmodule

@@ sv/pes_back.sv @@
// back end: alu, iterative divider, predictor update and output register
module pes_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_ready,
	input  pes_pkg::instr_t q_data,
	output logic            out_valid,
	input  logic            out_ready,
	output pes_pkg::result_t out_data
);
	typedef enum logic [1:0] {ST_CLEAR, ST_RUN, ST_JUMP, ST_DIV} state_t;

	// counter held as the low two bits of its 3-bit two's complement value
	localparam logic [1:0] CNT_MAX = 2'b10;
	localparam logic [1:0] CNT_MIN = 2'b11;

	state_t                       state_q;
	logic [pes_pkg::PredIdxW-1:0] clr_q;
	logic [pes_pkg::PredIdxW:0]   clr_next;
	logic [1:0]                   pcnt_q [pes_pkg::PredEntries];
	logic [1:0]                   cnt_rd_q;
	logic                         ovalid_q;
	pes_pkg::result_t             res_q;
	pes_pkg::result_t             res;
	pes_pkg::result_t             div_res;
	logic [15:0]                  quo_q;
	logic [16:0]                  rem_q;
	logic [15:0]                  dvs_q;
	logic [4:0]                   dcnt_q;
	logic [3:0]                   dreg_q;
	logic [16:0]                  rem_sh;
	logic [16:0]                  rem_sub;
	logic                         slot_free;
	logic                         take;
	logic                         is_jump;
	logic                         is_div;
	logic                         div_done;
	logic [pes_pkg::PredIdxW-1:0] pidx;
	logic [1:0]                   cnt_old;
	logic [1:0]                   cnt_new;
	logic                         taken;
	logic [15:0]                  actual;
	logic [31:0]                  prod;

	assign slot_free = ~ovalid_q | out_ready;
	assign is_jump = q_data.live & (q_data.cls == pes_pkg::CLS_JUMP);
	assign is_div = q_data.live & (q_data.cls == pes_pkg::CLS_DIV) & (q_data.value_b != 16'd0);
	assign div_done = (state_q == ST_DIV) & (dcnt_q == 5'd0);
	// jumps wait in ST_JUMP for the registered counter read, divides until the quotient is ready
	assign q_ready = slot_free & (((state_q == ST_RUN) & ~is_jump & ~is_div)
		| (state_q == ST_JUMP) | div_done);
	assign take = q_valid & q_ready;
	assign out_valid = ovalid_q;
	assign out_data = res_q;
	assign pidx = q_data.pc[pes_pkg::PredIdxW-1:0];
	assign cnt_old = cnt_rd_q;
	assign actual = q_data.value_a != 16'd0 ? q_data.immediate : 16'd0;
	assign taken = actual != 16'd0;
	assign clr_next = {1'b0, clr_q} + 1'b1;
	assign prod = q_data.value_a * q_data.value_b;
	assign rem_sh = {rem_q[15:0], quo_q[15]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_comb begin
		if (taken) cnt_new = (cnt_old == CNT_MAX) ? cnt_old : cnt_old + 2'd1;
		else cnt_new = (cnt_old == CNT_MIN) ? cnt_old : cnt_old - 2'd1;
	end

	always_comb begin
		div_res = '0;
		div_res.out_valid = 1'b1;
		div_res.write_reg = 1'b1;
		div_res.target_reg = dreg_q;
		div_res.alu_result = quo_q;
	end

	always_comb begin
		res = '0;
		if (q_data.live) begin
			res.out_valid = 1'b1;
			case (q_data.cls)
				pes_pkg::CLS_ALU, pes_pkg::CLS_DIV: begin
					res.write_reg = 1'b1;
					res.target_reg = q_data.dest_reg;
					case (q_data.opcode)
						pes_pkg::OP_ADD: res.alu_result = q_data.value_a + q_data.value_b;
						pes_pkg::OP_SUB: res.alu_result = q_data.value_a - q_data.value_b;
						pes_pkg::OP_MUL: res.alu_result = prod[15:0];
						pes_pkg::OP_DIV: res.alu_result = 16'hffff;
						pes_pkg::OP_EQ:  res.alu_result = 16'(q_data.value_a == q_data.value_b);
						pes_pkg::OP_NEQ: res.alu_result = 16'(q_data.value_a != q_data.value_b);
						pes_pkg::OP_LT:  res.alu_result = 16'(q_data.value_a < q_data.value_b);
						pes_pkg::OP_GT:  res.alu_result = 16'(q_data.value_a > q_data.value_b);
						pes_pkg::OP_LE:  res.alu_result = 16'(q_data.value_a <= q_data.value_b);
						pes_pkg::OP_GE:  res.alu_result = 16'(q_data.value_a >= q_data.value_b);
						pes_pkg::OP_AND: res.alu_result = q_data.value_a & q_data.value_b;
						pes_pkg::OP_OR:  res.alu_result = q_data.value_a | q_data.value_b;
						pes_pkg::OP_XOR: res.alu_result = q_data.value_a ^ q_data.value_b;
						pes_pkg::OP_SHL: res.alu_result = q_data.value_b[15:4] != 12'd0 ? 16'd0
							: q_data.value_a << q_data.value_b[3:0];
						default: res.alu_result = q_data.value_b[15:4] != 12'd0 ? 16'd0
							: q_data.value_a >> q_data.value_b[3:0];
					endcase
				end
				pes_pkg::CLS_LOAD: begin
					res.write_reg = 1'b1;
					res.target_reg = q_data.dest_reg;
					res.mem_access = pes_pkg::MEM_READ;
					res.mem_address = q_data.value_a;
				end
				pes_pkg::CLS_STORE: begin
					res.mem_access = pes_pkg::MEM_WRITE;
					res.mem_address = q_data.value_a;
					res.mem_write_data = q_data.value_b;
				end
				pes_pkg::CLS_SYS: res.halt = 1'b1;
				pes_pkg::CLS_JUMP: begin
					res.history_counter = {cnt_new == CNT_MIN, cnt_new};
					if (q_data.predicted_target != actual) begin
						res.redirect = 1'b1;
						res.redirect_pc = taken ? actual : {8'd0, q_data.pc} + 16'd1;
					end
				end
				pes_pkg::CLS_MOV: begin
					res.write_reg = 1'b1;
					res.target_reg = q_data.dest_reg;
					res.alu_result = q_data.immediate;
				end
				default: ;
			endcase
		end
	end

	// predictor counters: cleared by a sweep after reset, registered read at the head pc
	always_ff @(posedge clk) begin
		cnt_rd_q <= pcnt_q[pidx];
		if (state_q == ST_CLEAR) begin
			pcnt_q[clr_q] <= 2'd0;
		end else if (take & is_jump) begin
			pcnt_q[pidx] <= cnt_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			ovalid_q <= 1'b0;
			dcnt_q <= '0;
		end else begin
			if (take) begin
				ovalid_q <= 1'b1;
				res_q <= div_done ? div_res : res;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_next[pes_pkg::PredIdxW-1:0];
					if (clr_next[pes_pkg::PredIdxW]) state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (q_valid & is_jump) begin
						state_q <= ST_JUMP;
					end else if (q_valid & is_div) begin
						// restoring divide, one quotient bit a cycle
						state_q <= ST_DIV;
						quo_q <= q_data.value_a;
						rem_q <= '0;
						dvs_q <= q_data.value_b;
						dreg_q <= q_data.dest_reg;
						dcnt_q <= 5'd16;
					end
				end
				ST_JUMP: begin
					if (take) state_q <= ST_RUN;
				end
				ST_DIV: begin
					if (dcnt_q != 5'd0) begin
						dcnt_q <= dcnt_q - 5'd1;
						if (!rem_sub[16]) begin
							rem_q <= rem_sub;
							quo_q <= {quo_q[14:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							quo_q <= {quo_q[14:0], 1'b0};
						end
					end else if (take) begin
						state_q <= ST_RUN;
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end
endmodule

@@ sv/pipeline_execute_stage.sv @@
// top level of the execute stage: front classifier, queue and back execution
//
// channel  dir  tdata fields (lsb first)
// s_axis   in   flush, slot_valid, opcode, value_a, value_b, dest_reg, immediate, pc,
//               predicted_target
// m_axis   out  out_valid, write_reg, target_reg, alu_result, mem_access, mem_address,
//               mem_write_data, halt, redirect, redirect_pc, history_counter
//
// one instruction per cycle unless stalled, result registered on dequeue
// a conditional jump waits in ST_JUMP for the registered predictor counter read
// a nonzero divide runs in the shift-subtract divider
// after reset a sweep clears all 256 predictor entries before the first beat executes
// a two-entry queue between front and back lets input keep flowing while output stalls
module pipeline_execute_stage (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [87:0]  s_axis_tdata,  // flush, slot_valid, opcode, value_a, value_b,
	                                    // dest_reg, immediate, pc, predicted_target
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [79:0]  m_axis_tdata   // out_valid, write_reg, target_reg, alu_result,
	                                    // mem_access, mem_address, mem_write_data, halt,
	                                    // redirect, redirect_pc, history_counter
);
	pes_pkg::instr_t  qd;
	pes_pkg::result_t r;
	logic             qv;
	logic             qr;
	logic             unused_pad;

	pes_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_data(s_axis_tdata[82:0]),
		.q_valid(qv), .q_ready(qr), .q_data(qd)
	);

	pes_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(qv), .q_ready(qr), .q_data(qd),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(r)
	);

	assign unused_pad = ^s_axis_tdata[87:83];
	assign m_axis_tdata = {3'd0, r.history_counter, r.redirect_pc, r.redirect, r.halt,
		r.mem_write_data, r.mem_address, r.mem_access, r.alu_result, r.target_reg,
		r.write_reg, r.out_valid};
endmodule

@@ tb/sv/pipeline_execute_stage_test.sv @@
// testbench for the execute stage: random and directed instructions checked against a scoreboard
module pipeline_execute_stage_test;

	typedef struct packed {
		logic        flush;
		logic        slot_valid;
		logic [4:0]  opcode;
		logic [15:0] value_a;
		logic [15:0] value_b;
		logic [3:0]  dest_reg;
		logic [15:0] immediate;
		logic [7:0]  pc;
		logic [15:0] predicted_target;
	} slot_t;

	class exec_scoreboard;
		logic [15:0]      bp_target [pes_pkg::PredEntries];
		logic             bp_valid [pes_pkg::PredEntries];
		int               bp_counter [pes_pkg::PredEntries];
		pes_pkg::result_t pending [$];
		int               errors;

		function new();
			for (int i = 0; i < pes_pkg::PredEntries; i++) begin
				bp_target[i] = '0;
				bp_valid[i] = 1'b0;
				bp_counter[i] = 0;
			end
			errors = 0;
		endfunction

		function logic [15:0] alu_value(logic [4:0] op, logic [15:0] a, logic [15:0] b);
			case (op)
				pes_pkg::OP_ADD: return a + b;
				pes_pkg::OP_SUB: return a - b;
				pes_pkg::OP_MUL: return a * b;
				pes_pkg::OP_DIV: return (b == 0) ? 16'hffff : a / b;
				pes_pkg::OP_EQ: return {15'd0, a == b};
				pes_pkg::OP_NEQ: return {15'd0, a != b};
				pes_pkg::OP_LT: return {15'd0, a < b};
				pes_pkg::OP_GT: return {15'd0, a > b};
				pes_pkg::OP_LE: return {15'd0, a <= b};
				pes_pkg::OP_GE: return {15'd0, a >= b};
				pes_pkg::OP_AND: return a & b;
				pes_pkg::OP_OR: return a | b;
				pes_pkg::OP_XOR: return a ^ b;
				pes_pkg::OP_SHL: return (b >= 16) ? 16'd0 : a << b[3:0];
				default: return (b >= 16) ? 16'd0 : a >> b[3:0];
			endcase
		endfunction

		function void note_slot(slot_t s);
			pes_pkg::result_t r;
			logic [15:0] actual;
			int c;
			r = '0;
			if (!s.flush && s.slot_valid) begin
				r.out_valid = 1'b1;
				if (s.opcode <= pes_pkg::OP_SHR) begin
					r.write_reg = 1'b1;
					r.target_reg = s.dest_reg;
					r.alu_result = alu_value(s.opcode, s.value_a, s.value_b);
				end else if (s.opcode == pes_pkg::OP_LOAD) begin
					r.write_reg = 1'b1;
					r.target_reg = s.dest_reg;
					r.mem_access = pes_pkg::MEM_READ;
					r.mem_address = s.value_a;
				end else if (s.opcode == pes_pkg::OP_STORE) begin
					r.mem_access = pes_pkg::MEM_WRITE;
					r.mem_address = s.value_a;
					r.mem_write_data = s.value_b;
				end else if (s.opcode == pes_pkg::OP_SYSCALL) begin
					r.halt = 1'b1;
				end else if (s.opcode == pes_pkg::OP_JUMPCOND) begin
					actual = (s.value_a != 0) ? s.immediate : 16'd0;
					c = bp_counter[s.pc];
					bp_target[s.pc] = s.immediate;
					bp_valid[s.pc] = 1'b1;
					if (actual != 0) begin
						if (c < 2) c++;
					end else begin
						if (c > -1) c--;
					end
					bp_counter[s.pc] = c;
					r.history_counter = c[2:0];
					if (s.predicted_target != actual) begin
						r.redirect = 1'b1;
						r.redirect_pc = (actual != 0) ? actual : {8'd0, s.pc} + 16'd1;
					end
				end else if (s.opcode == pes_pkg::OP_MOV) begin
					r.write_reg = 1'b1;
					r.target_reg = s.dest_reg;
					r.alu_result = s.immediate;
				end
			end
			pending.push_back(r);
		endfunction

		function void check_result(pes_pkg::result_t got);
			pes_pkg::result_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result beat %h", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10) $display("result mismatch: expected %h actual %h", want, got);
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [87:0]  s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [79:0]  m_axis_tdata;

	exec_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	bit sending_done;

	pipeline_execute_stage dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// tdata carries the first field in the lowest bits
	function automatic logic [87:0] pack_slot(slot_t s);
		return {5'd0, s.predicted_target, s.pc, s.immediate, s.dest_reg, s.value_b,
			s.value_a, s.opcode, s.slot_valid, s.flush};
	endfunction

	function automatic pes_pkg::result_t unpack_result(logic [79:0] d);
		pes_pkg::result_t r;
		r.out_valid = d[0];
		r.write_reg = d[1];
		r.target_reg = d[5:2];
		r.alu_result = d[21:6];
		r.mem_access = d[23:22];
		r.mem_address = d[39:24];
		r.mem_write_data = d[55:40];
		r.halt = d[56];
		r.redirect = d[57];
		r.redirect_pc = d[73:58];
		r.history_counter = d[76:74];
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("CHECK FAILED");
		$finish;
	end

	// receiver side with random stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) sb.check_result(unpack_result(m_axis_tdata));
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_slot(slot_t s);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pack_slot(s);
		do @(posedge clk); while (!s_axis_tready);
		sb.note_slot(s);
	endtask

	function automatic slot_t random_slot();
		slot_t s;
		s = slot_t'(83'({$urandom, $urandom, $urandom}));
		s.flush = ($urandom_range(9) == 0);
		s.slot_valid = ($urandom_range(9) != 0);
		s.opcode = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(19));
		if ($urandom_range(3) == 0) s.value_b = 16'($urandom_range(20));
		if ($urandom_range(3) == 0) s.value_a = 16'd0;
		if ($urandom_range(3) == 0) s.immediate = 16'd0;
		if (s.opcode == pes_pkg::OP_JUMPCOND) begin
			s.pc = 8'($urandom_range(7));
			case ($urandom_range(2))
				0: s.predicted_target = 16'd0;
				1: s.predicted_target = s.immediate;
				default: ;
			endcase
		end
		return s;
	endfunction

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		slot_t s;
		sb = new();
		sending_done = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every opcode at field extremes, divide by zero, big shifts
		for (int op = 0; op < 21; op++) begin
			s = '0;
			s.slot_valid = 1'b1;
			s.opcode = 5'(op);
			s.value_a = (op % 2) ? 16'hffff : 16'h8001;
			s.value_b = (op == pes_pkg::OP_DIV) ? 16'd0
				: ((op >= pes_pkg::OP_SHL) ? 16'd16 : 16'hffff);
			s.dest_reg = 4'hf;
			s.immediate = 16'hffff;
			s.pc = 8'hff;
			s.predicted_target = 16'h0;
			send_slot(s);
		end
		s = '0; s.flush = 1'b1; s.slot_valid = 1'b1; s.opcode = pes_pkg::OP_ADD; send_slot(s);
		s = '0; s.opcode = pes_pkg::OP_MOV; s.immediate = 16'h1234; send_slot(s);
		// not-taken jump with zero immediate, then taken with wrong prediction
		s = '0; s.slot_valid = 1'b1; s.opcode = pes_pkg::OP_JUMPCOND; s.value_a = 16'd1;
		s.pc = 8'hff; s.predicted_target = 16'h55; send_slot(s);
		s.immediate = 16'h4000; s.predicted_target = 16'd0; send_slot(s);
		send_slot(s);
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 25 : 52) : 0;
			recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 25 : 52) : 0;
			for (int n = 0; n < 225; n++) send_slot(random_slot());
			if (phase == 1) wait_drained();
		end
		wait_drained();
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

@@ pipeline_execute_stage.f @@
sv/pes_pkg.sv
sv/pes_front.sv
sv/pes_back.sv
sv/pipeline_execute_stage.sv
tb/sv/pipeline_execute_stage_test.sv
